// ===== rtl/core/lsc_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the
// sector cache. No dependencies.

package lsc_pkg;

    localparam int LINES     = 8;
    localparam int DATA_BITS = 64;

    localparam int LINE_W = $clog2(LINES);
    localparam int CNT_W  = $clog2(LINES + 1);

    localparam int KEY_W       = 16;
    localparam int IO_DATA_W   = 64;
    localparam int LINE_OUT_W  = 6;
    localparam int CFG_W       = 7;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CFG_W-1:0] LINES_IN_USE_RESET = 7'd8;

    // register indexes, taken from paddr[2]
    localparam logic REG_LINES_IN_USE = 1'b0;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic decide;
        logic scan_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit_any;
        logic free_any;
        logic is_put;
        logic single_line;
        logic scan_last;
    } t_sts;

endpackage

// ===== rtl/core/lsc_ctrl.sv =====
// Request sequencer for the sector cache: state machine, input stall and
// output valid. Depends on lsc_pkg.

module lsc_ctrl
    import lsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.hit_any || !i_sts.is_put || i_sts.free_any || i_sts.single_line) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/lsc_dpath.sv =====
// Sector cache datapath: line storage, tag match, free/victim selection,
// recency ranks and the result register. Depends on lsc_pkg.

module lsc_dpath
    import lsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [CFG_W-1:0]      i_lines_in_use,
    input  logic                  i_req_type,
    input  logic [KEY_W-1:0]      i_track,
    input  logic [KEY_W-1:0]      i_sector,
    input  logic [IO_DATA_W-1:0]  i_put_data,
    output logic                  o_hit,
    output logic [IO_DATA_W-1:0]  o_read_data,
    output logic [LINE_OUT_W-1:0] o_line_used,
    output logic                  o_evicted
);

    localparam logic [LINE_W-1:0] RANK_MAX = LINE_W'(LINES - 1);
    localparam logic [LINE_W:0]   RANK_NONE = (LINE_W + 1)'(LINES);

    // lowest set bit of a line vector
    function automatic logic [LINE_W-1:0] first_set(input logic [LINES-1:0] v);
        logic [LINE_W-1:0] idx;
        idx = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = LINE_W'(i);
            end
        end
        return idx;
    endfunction

    logic                 r_req_put;
    logic [KEY_W-1:0]     r_req_track;
    logic [KEY_W-1:0]     r_req_sector;
    logic [DATA_BITS-1:0] r_req_data;

    logic [LINES-1:0]     r_valid;
    logic [KEY_W-1:0]     r_tag_track  [LINES];
    logic [KEY_W-1:0]     r_tag_sector [LINES];
    logic [DATA_BITS-1:0] r_data       [LINES];
    logic [LINE_W-1:0]    r_rank       [LINES];

    logic [LINES-1:0]     r_match;
    logic [LINES-1:0]     r_free;
    logic                 r_hit;
    logic [LINE_W-1:0]    r_hit_idx;
    logic                 r_free_any;
    logic [LINE_W-1:0]    r_free_idx;
    logic [LINE_W-1:0]    r_best_idx;
    logic [LINE_W-1:0]    r_best_rank;
    logic [LINE_W-1:0]    r_scan_idx;

    logic                  r_o_hit;
    logic [IO_DATA_W-1:0]  r_o_read_data;
    logic [LINE_OUT_W-1:0] r_o_line_used;
    logic                  r_o_evicted;

    logic [CNT_W-1:0]  w_n;
    logic [LINES-1:0]  w_in_use;
    logic              w_evict;
    logic              w_get_miss;
    logic [LINE_W-1:0] w_used;
    logic [LINE_W:0]   w_old_rank;

    // zero lines acts as one, anything beyond the built count as all of them
    always_comb begin
        priority if (i_lines_in_use == '0) begin
            w_n = CNT_W'(1);
        end else if (i_lines_in_use > CFG_W'(LINES)) begin
            w_n = CNT_W'(LINES);
        end else begin
            w_n = CNT_W'(i_lines_in_use);
        end
    end

    always_comb begin
        for (int j = 0; j < LINES; j++) begin
            w_in_use[j] = CNT_W'(j) < w_n;
        end
    end

    assign w_evict    = r_req_put && !r_hit && !r_free_any;
    assign w_get_miss = !r_req_put && !r_hit;
    assign w_used     = r_hit ? r_hit_idx : (r_free_any ? r_free_idx : r_best_idx);
    assign w_old_rank = (r_hit || w_evict) ? {1'b0, r_rank[w_used]} : RANK_NONE;

    assign o_sts.hit_any     = |r_match;
    assign o_sts.free_any    = |r_free;
    assign o_sts.is_put      = r_req_put;
    assign o_sts.single_line = w_n == CNT_W'(1);
    assign o_sts.scan_last   = r_scan_idx == LINE_W'(w_n - CNT_W'(1));

    // request and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_put    <= i_req_type;
            r_req_track  <= i_track;
            r_req_sector <= i_sector;
            r_req_data   <= i_put_data[DATA_BITS-1:0];
        end
        if (i_cmd.match) begin
            for (int j = 0; j < LINES; j++) begin
                r_match[j] <= r_valid[j] && w_in_use[j] && r_tag_track[j] == r_req_track
                              && r_tag_sector[j] == r_req_sector;
                r_free[j]  <= !r_valid[j] && w_in_use[j];
            end
        end
        if (i_cmd.decide) begin
            r_hit       <= |r_match;
            r_hit_idx   <= first_set(r_match);
            r_free_any  <= |r_free;
            r_free_idx  <= first_set(r_free);
            r_best_idx  <= '0;
            r_best_rank <= r_rank[0];
            r_scan_idx  <= LINE_W'(1);
        end
        // victim scan: one rank per cycle, strict compare keeps the lowest index
        if (i_cmd.scan_step) begin
            if (r_rank[r_scan_idx] > r_best_rank) begin
                r_best_idx  <= r_scan_idx;
                r_best_rank <= r_rank[r_scan_idx];
            end
            r_scan_idx <= r_scan_idx + LINE_W'(1);
        end
    end

    // line contents and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_req_put) begin
                r_data[w_used] <= r_req_data;
                if (!r_hit) begin
                    r_tag_track[w_used]  <= r_req_track;
                    r_tag_sector[w_used] <= r_req_sector;
                end
            end
            r_o_hit       <= r_hit;
            r_o_read_data <= (r_hit && !r_req_put) ? IO_DATA_W'(r_data[w_used]) : '0;
            r_o_line_used <= w_get_miss ? '0 : LINE_OUT_W'(w_used);
            r_o_evicted   <= w_evict;
        end
    end

    // valid bits and recency ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int j = 0; j < LINES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_cmd.commit && !w_get_miss) begin
            for (int j = 0; j < LINES; j++) begin
                if (LINE_W'(j) == w_used) begin
                    r_rank[j] <= '0;
                end else if (r_valid[j] && {1'b0, r_rank[j]} < w_old_rank
                             && r_rank[j] < RANK_MAX) begin
                    r_rank[j] <= r_rank[j] + LINE_W'(1);
                end
            end
            if (r_req_put) begin
                r_valid[w_used] <= 1'b1;
            end
        end
    end

    assign o_hit       = r_o_hit;
    assign o_read_data = r_o_read_data;
    assign o_line_used = r_o_line_used;
    assign o_evicted   = r_o_evicted;

    a_fill_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_req_put && !r_hit && r_free_any |-> !r_valid[w_used])
        else $error("fill targets a valid line");

    a_put_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_req_put |=> r_valid[$past(w_used)])
        else $error("put left its line invalid");

    a_touch_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !w_get_miss |=> r_rank[$past(w_used)] == '0)
        else $error("touched line is not most recent");

    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !w_get_miss |-> CNT_W'(w_used) < w_n)
        else $error("line used lies beyond lines in use");

endmodule

// ===== rtl/core/lru_sector_cache.sv =====
// Top level of the LRU sector cache: configuration register, sequencer and
// datapath. Depends on lsc_pkg, lsc_ctrl and lsc_dpath.
//
//   port group   direction  handshake               payload
//   request      in         i_in_valid/o_in_stall   i_req_type i_track i_sector i_put_data
//   result       out        o_out_valid/i_out_stall o_hit o_read_data o_line_used o_evicted
//   config       in         psel/penable/pwrite     paddr pwdata prdata (pready tied high)
//
// A request goes through match, decide and commit from one transfer to the next transfer.
// A put that must replace a line also scans n lines, n being lines_in_use clamped to 1..8:
// the victim search reads one recency rank per cycle. A stalled result holds the commit
// step until it can load.
// Reset (synchronous) clears all valid bits and ranks at once and sets lines_in_use to 8.

module lru_sector_cache
    import lsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [KEY_W-1:0]      i_track,
    input  logic [KEY_W-1:0]      i_sector,
    input  logic [IO_DATA_W-1:0]  i_put_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [IO_DATA_W-1:0]  o_read_data,
    output logic [LINE_OUT_W-1:0] o_line_used,
    output logic                  o_evicted,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_lines_in_use;
    logic             w_cfg_write;
    t_cmd             w_cmd;
    t_sts             w_sts;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_in_use <= LINES_IN_USE_RESET;
        end else if (w_cfg_write && paddr[2] == REG_LINES_IN_USE) begin
            r_lines_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LINES_IN_USE) ? APB_DATA_W'(r_lines_in_use) : '0;

    lsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lsc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_lines_in_use (r_lines_in_use),
        .i_req_type     (i_req_type),
        .i_track        (i_track),
        .i_sector       (i_sector),
        .i_put_data     (i_put_data),
        .o_hit          (o_hit),
        .o_read_data    (o_read_data),
        .o_line_used    (o_line_used),
        .o_evicted      (o_evicted)
    );

endmodule
